/* hdl/three_plane_intersection_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the three-plane intersection block
// Implication checks sampled on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef THREE_PLANE_INTERSECTION_MACROS_SVH
`define THREE_PLANE_INTERSECTION_MACROS_SVH
`ifndef ASSERT_OFF
`define TPI_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("three_plane_intersection: implication check failed");
`define TPI_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("three_plane_intersection: next-cycle check failed");
`else
`define TPI_ASSERT_IMPLY(label, clk, rst, pre, post)
`define TPI_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* hdl/tpi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-plane intersection package
// Result status codes and control register indices and reset values.
// ----------------------------------------------------------------------------
package tpi_pkg;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_INVALID   = 3'd1,
      STATUS_PARALLEL  = 3'd2,
      STATUS_SINGULAR  = 3'd3,
      STATUS_SATURATED = 3'd4
   } status_type;

   localparam logic CSR_MIN_LEN_SQ = 1'b0;
   localparam logic CSR_PAR_LIMIT  = 1'b1;

   localparam logic [15:0] MIN_LEN_SQ_RESET = 16'd13271;
   localparam logic [14:0] PAR_LIMIT_RESET  = 15'd16220;

endpackage

/* hdl/three_plane_intersection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-plane intersection
// Finds the common point of three planes n.p + d = 0, or reports why not.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream: three planes, each a Q2.14 normal and a
// Q16.16 offset. Each request gives one result on the rsp_ stream: a status
// and the point in Q16.16. Invalid planes, near-parallel pairs and a zero
// triple product give a zero point with their status; a clamped coordinate
// gives the saturated status.
// The user must write the two thresholds through the csr_ port only while the
// block is idle; the block does not enforce this. pready is always high.
// The block is a pipeline of COORD_WIDTH + 8 stages (40 by default): six
// arithmetic stages, one restoring-divider stage per quotient bit, and the
// output register. One request can be accepted in every cycle until a stall of
// the receiver has filled every stage. The length is set by the per-bit
// divider stages.
// When the receiver stalls, the stages ahead of the output keep filling
// their empty slots; req_tready falls only once every stage holds a request.
// Reset clears all valid bits and restores both thresholds.
// ----------------------------------------------------------------------------
`include "three_plane_intersection_macros.svh"

module three_plane_intersection
   import tpi_pkg::*;
#(
   parameter int NORMAL_WIDTH = 16,
   parameter int COORD_WIDTH  = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // per plane 1..3: normal_x, normal_y, normal_z, distance
   input  logic [((3*(3*NORMAL_WIDTH+COORD_WIDTH)+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status, point_x, point_y, point_z
   output logic [((3+3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int NW    = NORMAL_WIDTH;
   localparam int CW    = COORD_WIDTH;
   localparam int NF    = NW - 2;
   localparam int THR   = 2*NF - 14;
   localparam int PW    = 2*NW;
   localparam int DOTW  = 2*NW + 2;
   localparam int CRW   = 2*NW + 1;
   localparam int DPW   = NW + CRW;
   localparam int DENW  = DPW + 2;
   localparam int NPW   = CW + CRW;
   localparam int NUMW  = NPW + 2;
   localparam int QB    = CW + 1;
   localparam int DIVW  = DENW + 1;
   localparam int DVA   = NUMW + NF + 2;
   localparam int DVB   = DIVW + QB;
   localparam int DVW   = (DVA > DVB) ? DVA : DVB;
   localparam int PLW   = 3*NW + CW;
   localparam int RSP_F = 3 + 3*CW;
   localparam int RSP_W = ((RSP_F+7)/8)*8;
   localparam int S_DIV = 6;
   localparam int S_OUT = S_DIV + QB;
   localparam int NSTG  = S_OUT + 1;

   localparam logic [QB-1:0] LIM = QB'(1) << (CW-1);

   // control registers
   logic [15:0] min_len_ff;
   logic [14:0] par_lim_ff;
   logic        csr_wr;

   // handshake chain
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] rdy;

   // stage 0
   logic signed [NW-1:0] n0_ff [3][3];
   logic signed [CW-1:0] d0_ff [3];
   // stage 1
   logic signed [PW-1:0] sq1_in [3][3];
   logic signed [PW-1:0] dp1_in [3][3];
   logic signed [PW-1:0] cp1_in [3][3][2];
   logic signed [PW-1:0] sq1_ff [3][3];
   logic signed [PW-1:0] dp1_ff [3][3];
   logic signed [PW-1:0] cp1_ff [3][3][2];
   logic signed [NW-1:0] n1_ff [3];
   logic signed [CW-1:0] d1_ff [3];
   // stage 2
   logic signed [CRW-1:0] c2_in [3][3];
   logic                  inv2_in, par2_in;
   logic signed [CRW-1:0] c2_ff [3][3];
   logic signed [NW-1:0]  n2_ff [3];
   logic signed [CW-1:0]  d2_ff [3];
   logic                  inv2_ff, par2_ff;
   // stage 3
   logic signed [DPW-1:0] denp3_in [3];
   logic signed [NPW-1:0] nump3_in [3][3];
   logic signed [DPW-1:0] denp3_ff [3];
   logic signed [NPW-1:0] nump3_ff [3][3];
   logic                  inv3_ff, par3_ff;
   // stage 4
   logic signed [DENW-1:0] den4_in;
   logic signed [NUMW-1:0] num4_in [3];
   status_type             st4_in;
   logic signed [DENW-1:0] den4_ff;
   logic signed [NUMW-1:0] num4_ff [3];
   status_type             st4_ff;
   // stage 5
   logic [DVW-1:0]  dvd5_in [3];
   logic [DIVW-1:0] div5_in;
   logic            neg5_in [3];
   logic [DVW-1:0]  dvd5_ff [3];
   logic [DIVW-1:0] div5_ff;
   logic            neg5_ff [3];
   status_type      st5_ff;
   // divider stages
   logic [DVW-1:0]  rem_in [QB][3];
   logic [QB-1:0]   q_in   [QB][3];
   logic            ovf_in [QB][3];
   logic [DVW-1:0]  rem_ff [QB][3];
   logic [QB-1:0]   q_ff   [QB][3];
   logic            ovf_ff [QB][3];
   logic            neg_ff [QB][3];
   logic [DIVW-1:0] dv_ff  [QB];
   status_type      st_ff  [QB];
   // output
   status_type      rsp_status_in, rsp_status_ff;
   logic [CW-1:0]   point_in [3];
   logic [CW-1:0]   point_ff [3];

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= MIN_LEN_SQ_RESET;
         par_lim_ff <= PAR_LIMIT_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_MIN_LEN_SQ: min_len_ff <= csr_pwdata[15:0];
            CSR_PAR_LIMIT:  par_lim_ff <= csr_pwdata[14:0];
            default:        min_len_ff <= min_len_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_MIN_LEN_SQ: csr_prdata = {16'd0, min_len_ff};
         CSR_PAR_LIMIT:  csr_prdata = {17'd0, par_lim_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- handshake
   always_comb begin
      rdy[NSTG-1] = !v_ff[NSTG-1] || rsp_tready;
      for (int k = NSTG-2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = v_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // ------------------------------------------------------------ stage 0
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               n0_ff[i][k] <= req_tdata[i*PLW + k*NW +: NW];
            end
            d0_ff[i] <= req_tdata[i*PLW + 3*NW +: CW];
         end
      end
   end

   // ------------------------------------------------------------ stage 1
   always_comb begin
      int pa, pb, ca, cb;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            sq1_in[i][k] = PW'(n0_ff[i][k]) * PW'(n0_ff[i][k]);
         end
      end
      for (int p = 0; p < 3; p++) begin
         pa = (p == 2) ? 1 : 0;
         pb = (p == 0) ? 1 : 2;
         for (int k = 0; k < 3; k++) begin
            dp1_in[p][k] = PW'(n0_ff[pa][k]) * PW'(n0_ff[pb][k]);
         end
      end
      for (int m = 0; m < 3; m++) begin
         ca = (m + 1) % 3;
         cb = (m + 2) % 3;
         for (int k = 0; k < 3; k++) begin
            cp1_in[m][k][0] = PW'(n0_ff[ca][(k+1)%3]) * PW'(n0_ff[cb][(k+2)%3]);
            cp1_in[m][k][1] = PW'(n0_ff[ca][(k+2)%3]) * PW'(n0_ff[cb][(k+1)%3]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         sq1_ff <= sq1_in;
         dp1_ff <= dp1_in;
         cp1_ff <= cp1_in;
         n1_ff  <= n0_ff[0];
         d1_ff  <= d0_ff;
      end
   end

   // ------------------------------------------------------------ stage 2
   always_comb begin
      logic signed [DOTW-1:0] len_lim;
      logic signed [DOTW-1:0] par_lim;
      logic signed [DOTW-1:0] lensq;
      logic signed [DOTW-1:0] dot;
      len_lim = DOTW'(min_len_ff) << THR;
      par_lim = DOTW'(par_lim_ff) << THR;
      inv2_in = 1'b0;
      par2_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         lensq = DOTW'(sq1_ff[i][0]) + DOTW'(sq1_ff[i][1]) + DOTW'(sq1_ff[i][2]);
         if (lensq <= len_lim) begin
            inv2_in = 1'b1;
         end
         dot = DOTW'(dp1_ff[i][0]) + DOTW'(dp1_ff[i][1]) + DOTW'(dp1_ff[i][2]);
         if (dot >= par_lim || dot <= -par_lim) begin
            par2_in = 1'b1;
         end
      end
      for (int m = 0; m < 3; m++) begin
         for (int k = 0; k < 3; k++) begin
            c2_in[m][k] = CRW'(cp1_ff[m][k][0]) - CRW'(cp1_ff[m][k][1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         c2_ff   <= c2_in;
         n2_ff   <= n1_ff;
         d2_ff   <= d1_ff;
         inv2_ff <= inv2_in;
         par2_ff <= par2_in;
      end
   end

   // ------------------------------------------------------------ stage 3
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         denp3_in[k] = DPW'(n2_ff[k]) * DPW'(c2_ff[0][k]);
         for (int m = 0; m < 3; m++) begin
            nump3_in[m][k] = NPW'(d2_ff[m]) * NPW'(c2_ff[m][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         denp3_ff <= denp3_in;
         nump3_ff <= nump3_in;
         inv3_ff  <= inv2_ff;
         par3_ff  <= par2_ff;
      end
   end

   // ------------------------------------------------------------ stage 4
   always_comb begin
      den4_in = DENW'(denp3_ff[0]) + DENW'(denp3_ff[1]) + DENW'(denp3_ff[2]);
      for (int k = 0; k < 3; k++) begin
         num4_in[k] = -(NUMW'(nump3_ff[0][k]) + NUMW'(nump3_ff[1][k])
                        + NUMW'(nump3_ff[2][k]));
      end
      priority if (inv3_ff) begin
         st4_in = STATUS_INVALID;
      end else if (par3_ff) begin
         st4_in = STATUS_PARALLEL;
      end else if (den4_in == '0) begin
         st4_in = STATUS_SINGULAR;
      end else begin
         st4_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         den4_ff <= den4_in;
         num4_ff <= num4_in;
         st4_ff  <= st4_in;
      end
   end

   // ------------------------------------------------------------ stage 5
   always_comb begin
      logic [DENW-1:0] aden;
      logic [NUMW-1:0] mag;
      aden    = den4_ff[DENW-1] ? DENW'(-den4_ff) : DENW'(den4_ff);
      div5_in = {aden, 1'b0};
      for (int k = 0; k < 3; k++) begin
         mag        = num4_ff[k][NUMW-1] ? NUMW'(-num4_ff[k]) : NUMW'(num4_ff[k]);
         neg5_in[k] = num4_ff[k][NUMW-1] ^ den4_ff[DENW-1];
         dvd5_in[k] = (DVW'(mag) << (NF+1)) + DVW'(aden);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         dvd5_ff <= dvd5_in;
         div5_ff <= div5_in;
         neg5_ff <= neg5_in;
         st5_ff  <= st4_ff;
      end
   end

   // ------------------------------------------------------- divider stages
   always_comb begin
      logic [DVW-1:0] sh;
      sh = DVW'(div5_ff) << (QB-1);
      for (int l = 0; l < 3; l++) begin
         ovf_in[0][l] = dvd5_ff[l] >= (DVW'(div5_ff) << QB);
         if (dvd5_ff[l] >= sh) begin
            rem_in[0][l] = dvd5_ff[l] - sh;
            q_in[0][l]   = LIM << 1;
         end else begin
            rem_in[0][l] = dvd5_ff[l];
            q_in[0][l]   = '0;
         end
      end
      for (int j = 1; j < QB; j++) begin
         sh = DVW'(dv_ff[j-1]) << (QB-1-j);
         for (int l = 0; l < 3; l++) begin
            ovf_in[j][l] = ovf_ff[j-1][l];
            if (rem_ff[j-1][l] >= sh) begin
               rem_in[j][l] = rem_ff[j-1][l] - sh;
               q_in[j][l]   = q_ff[j-1][l] | (QB'(1) << (QB-1-j));
            end else begin
               rem_in[j][l] = rem_ff[j-1][l];
               q_in[j][l]   = q_ff[j-1][l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[S_DIV]) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         ovf_ff[0] <= ovf_in[0];
         neg_ff[0] <= neg5_ff;
         dv_ff[0]  <= div5_ff;
         st_ff[0]  <= st5_ff;
      end
      for (int j = 1; j < QB; j++) begin
         if (rdy[S_DIV+j]) begin
            rem_ff[j] <= rem_in[j];
            q_ff[j]   <= q_in[j];
            ovf_ff[j] <= ovf_in[j];
            neg_ff[j] <= neg_ff[j-1];
            dv_ff[j]  <= dv_ff[j-1];
            st_ff[j]  <= st_ff[j-1];
         end
      end
   end

   // ------------------------------------------------------------- output
   always_comb begin
      logic [QB-1:0] q;
      logic [QB-1:0] nq;
      logic          sat;
      sat = 1'b0;
      for (int l = 0; l < 3; l++) begin
         q  = q_ff[QB-1][l];
         nq = -q;
         if (neg_ff[QB-1][l]) begin
            if (ovf_ff[QB-1][l] || q > LIM) begin
               point_in[l] = {1'b1, {(CW-1){1'b0}}};
               sat         = 1'b1;
            end else begin
               point_in[l] = nq[CW-1:0];
            end
         end else begin
            if (ovf_ff[QB-1][l] || q >= LIM) begin
               point_in[l] = {1'b0, {(CW-1){1'b1}}};
               sat         = 1'b1;
            end else begin
               point_in[l] = q[CW-1:0];
            end
         end
      end
      if (st_ff[QB-1] != STATUS_OK) begin
         rsp_status_in = st_ff[QB-1];
         for (int l = 0; l < 3; l++) begin
            point_in[l] = '0;
         end
      end else if (sat) begin
         rsp_status_in = STATUS_SATURATED;
      end else begin
         rsp_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[S_OUT]) begin
         rsp_status_ff <= rsp_status_in;
         point_ff      <= point_in;
      end
   end

   assign rsp_tdata = RSP_W'({point_ff[2], point_ff[1], point_ff[0], rsp_status_ff});

   // --------------------------------------------------------- assertions
   `TPI_ASSERT_IMPLY(a_stall_from_output, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)
   `TPI_ASSERT_IMPLY(a_reject_zero_point, clock, reset, rsp_tvalid && (rsp_status_ff == STATUS_INVALID || rsp_status_ff == STATUS_PARALLEL || rsp_status_ff == STATUS_SINGULAR), point_ff[0] == '0 && point_ff[1] == '0 && point_ff[2] == '0)
   `TPI_ASSERT_NEXT(a_drain_empty, clock, reset, rsp_tvalid && rsp_tready && !v_ff[NSTG-2], !rsp_tvalid)

endmodule

/* tb/three_plane_intersection_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-plane intersection checker
// Watches the request, result and register ports, predicts the point or the
// status of every accepted request and compares it with the block's result.
// ----------------------------------------------------------------------------
module three_plane_intersection_checker
   import tpi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [239:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending_points,
   output int           ok_count,
   output int           saturated_count
);

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [31:0] point_z;
      logic [31:0] point_y;
      logic [31:0] point_x;
      status_type  status;
   } point_type;

   logic [15:0] min_len_sq;
   logic [14:0] par_limit;
   point_type   expected_points[$];

   function automatic wide_type dot3(wide_type a[3], wide_type b[3]);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
   endfunction

   function automatic wide_type magnitude(wide_type v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic point_type solve_planes(logic [239:0] data, logic [15:0] len_thr,
                                              logic [14:0] par_thr);
      wide_type  n[3][3];
      wide_type  offset[3];
      wide_type  c23[3], c31[3], c12[3];
      wide_type  den, aden, num, mag, len_lim, par_lim;
      logic [31:0] coord[3];
      point_type res;
      logic      neg;
      res = '0;
      res.status = STATUS_OK;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++)
            n[i][k] = wide_type'($signed(data[80*i + 16*k +: 16]));
         offset[i] = wide_type'($signed(data[80*i + 48 +: 32]));
      end
      len_lim = wide_type'(len_thr) <<< 14;
      par_lim = wide_type'(par_thr) <<< 14;
      for (int i = 0; i < 3; i++)
         if (dot3(n[i], n[i]) <= len_lim) begin
            res.status = STATUS_INVALID;
            return res;
         end
      if (magnitude(dot3(n[0], n[1])) >= par_lim || magnitude(dot3(n[0], n[2])) >= par_lim
          || magnitude(dot3(n[1], n[2])) >= par_lim) begin
         res.status = STATUS_PARALLEL;
         return res;
      end
      c23[0] = n[1][1] * n[2][2] - n[1][2] * n[2][1];
      c23[1] = n[1][2] * n[2][0] - n[1][0] * n[2][2];
      c23[2] = n[1][0] * n[2][1] - n[1][1] * n[2][0];
      c31[0] = n[2][1] * n[0][2] - n[2][2] * n[0][1];
      c31[1] = n[2][2] * n[0][0] - n[2][0] * n[0][2];
      c31[2] = n[2][0] * n[0][1] - n[2][1] * n[0][0];
      c12[0] = n[0][1] * n[1][2] - n[0][2] * n[1][1];
      c12[1] = n[0][2] * n[1][0] - n[0][0] * n[1][2];
      c12[2] = n[0][0] * n[1][1] - n[0][1] * n[1][0];
      den = dot3(n[0], c23);
      if (den == 0) begin
         res.status = STATUS_SINGULAR;
         return res;
      end
      aden = magnitude(den);
      for (int k = 0; k < 3; k++) begin
         num = -(offset[0] * c23[k] + offset[1] * c31[k] + offset[2] * c12[k]);
         neg = (num < 0) != (den < 0);
         mag = ((magnitude(num) <<< 15) + aden) / (aden <<< 1);
         if (neg) begin
            if (mag > wide_type'(64'h8000_0000)) begin
               coord[k] = 32'h8000_0000;
               res.status = STATUS_SATURATED;
            end else begin
               coord[k] = -mag[31:0];
            end
         end else begin
            if (mag > wide_type'(64'h7FFF_FFFF)) begin
               coord[k] = 32'h7FFF_FFFF;
               res.status = STATUS_SATURATED;
            end else begin
               coord[k] = mag[31:0];
            end
         end
      end
      res.point_x = coord[0];
      res.point_y = coord[1];
      res.point_z = coord[2];
      return res;
   endfunction

   always @(posedge clock) begin
      point_type got, want;
      if (reset) begin
         min_len_sq <= MIN_LEN_SQ_RESET;
         par_limit  <= PAR_LIMIT_RESET;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == CSR_MIN_LEN_SQ)
               min_len_sq <= csr_pwdata[15:0];
            else
               par_limit <= csr_pwdata[14:0];
         end
         if (req_tvalid && req_tready)
            expected_points.push_back(solve_planes(req_tdata, min_len_sq, par_limit));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[98:0];
            if (expected_points.size() == 0) begin
               fail_count++;
               $display("%0t: result with no request outstanding, actual %h", $time, got);
            end else begin
               want = expected_points.pop_front();
               if (got.status == STATUS_OK)
                  ok_count++;
               if (got.status == STATUS_SATURATED)
                  saturated_count++;
               if (got.status != want.status || got.point_x != want.point_x
                   || got.point_y != want.point_y || got.point_z != want.point_z) begin
                  fail_count++;
                  $display("%0t: mismatch status exp %0d act %0d", $time, want.status,
                           got.status);
                  $display("   point exp %h %h %h act %h %h %h", want.point_x, want.point_y,
                           want.point_z, got.point_x, got.point_y, got.point_z);
               end
            end
         end
      end
      pending_points = expected_points.size();
   end

endmodule

/* tb/tb_three_plane_intersection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-plane intersection testbench
// Drives directed and random plane triples through several threshold
// settings with random gaps on both streams; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_three_plane_intersection
   import tpi_pkg::*;
;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [239:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           fail_count;
   int           pending_points;
   int           ok_count;
   int           saturated_count;
   int           cycle_count;
   int           sent_count;
   int           rsp_wait;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [15:0] ONE_Q14 = 16'd16384;

   three_plane_intersection i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .rsp_tvalid, .rsp_tready,
      .rsp_tdata, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   three_plane_intersection_checker i_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .rsp_tvalid, .rsp_tready,
      .rsp_tdata, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_pready, .fail_count, .pending_points, .ok_count, .saturated_count
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The result side stalls for a random number of cycles after each result.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_wait   <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [79:0] plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                                         logic [31:0] offset);
      return {offset, nz, ny, nx};
   endfunction

   function automatic logic [15:0] random_component();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic logic [31:0] random_distance();
      if ($urandom_range(0, 9) == 0)
         return $urandom();
      return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
   endfunction

   // A normal with one large component on a random axis, long enough to pass the default threshold.
   function automatic logic [79:0] random_plane();
      logic [15:0] comp[3];
      int          axis;
      axis = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++)
         comp[k] = random_component();
      comp[axis] = 16'($urandom_range(15000, 16384));
      if ($urandom_range(0, 1))
         comp[axis] = -comp[axis];
      return plane(comp[0], comp[1], comp[2], random_distance());
   endfunction

   task automatic send_request(logic [239:0] data);
      int gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0)
         gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_points != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_register(logic index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(int count);
      logic [239:0] data;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0)
            data = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), 16'($urandom())};
         else
            data = {random_plane(), random_plane(), random_plane()};
         send_request(data);
         if (i == count / 2 && $urandom_range(0, 1)) begin
            req_tvalid <= 1'b0;
            while (pending_points != 0) @(posedge clock);
         end
      end
      drain();
   endtask

   initial begin
      sent_count  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Axis-aligned planes, extreme offsets, a zero normal, parallel pairs,
      // a coplanar triple and coordinate overflow in both directions.
      send_request({plane(0, 0, ONE_Q14, 32'h0001_0000), plane(0, ONE_Q14, 0, 32'hFFFE_0000),
                    plane(ONE_Q14, 0, 0, 32'h0003_0000)});
      send_request({plane(0, 0, ONE_Q14, 32'h7FFF_FFFF), plane(0, ONE_Q14, 0, 32'h8000_0000),
                    plane(ONE_Q14, 0, 0, 32'h7FFF_FFFF)});
      send_request({plane(0, 0, 16'h8000, 32'h8000_0000), plane(0, 16'h8000, 0, 32'h7FFF_FFFF),
                    plane(16'h8000, 0, 0, 32'h8000_0000)});
      send_request({plane(0, 0, 16'h7FFF, 0), plane(0, 16'h7FFF, 0, 0),
                    plane(16'h7FFF, 0, 0, 0)});
      send_request({plane(0, 0, ONE_Q14, 1), plane(0, ONE_Q14, 0, 1), plane(0, 0, 0, 1)});
      send_request({plane(0, 0, ONE_Q14, 1), plane(ONE_Q14, 0, 0, 1),
                    plane(16'd10000, 0, 0, 1)});
      send_request({plane(ONE_Q14, 0, 0, 1), plane(0, ONE_Q14, 0, 2),
                    plane(16'd11585, 16'd11585, 0, 3)});
      send_request({plane(16'd11585, 16'd11585, 0, 32'h7FFF_FFFF),
                    plane(16'd11585, 16'd11586, 0, 32'h8000_0000),
                    plane(0, 0, ONE_Q14, 32'h7FFF_FFFF)});
      send_request({plane(16'd11585, 16'd11585, 0, 0), plane(16'd11585, 16'd11586, 0, 5),
                    plane(0, 0, ONE_Q14, 0)});
      send_request({plane(0, 0, ONE_Q14, 32'hFFFF_FFFF), plane(0, ONE_Q14, 0, 32'hFFFF_FFFF),
                    plane(ONE_Q14, 0, 0, 32'hFFFF_FFFF)});
      send_request({plane(16'd14745, 0, 0, 7), plane(0, ONE_Q14, 0, 7),
                    plane(0, 0, ONE_Q14, 7)});
      send_request({plane(16'd14746, 0, 0, 7), plane(0, ONE_Q14, 0, 7),
                    plane(0, 0, ONE_Q14, 7)});
      drain();
      random_phase(400);

      write_register(CSR_MIN_LEN_SQ, 32'd0);
      write_register(CSR_PAR_LIMIT, 32'd32767);
      send_request({plane(0, 0, 1, 1), plane(0, 1, 0, 1), plane(1, 0, 0, 1)});
      send_request({plane(0, 0, 16'h8000, 9), plane(0, 16'h8000, 0, 9),
                    plane(16'h7FFF, 16'h7FFF, 0, 9)});
      random_phase(300);

      write_register(CSR_MIN_LEN_SQ, 32'd65535);
      write_register(CSR_PAR_LIMIT, 32'd0);
      random_phase(40);

      write_register(CSR_MIN_LEN_SQ, 32'd2000);
      write_register(CSR_PAR_LIMIT, 32'd0);
      random_phase(40);

      write_register(CSR_MIN_LEN_SQ, 32'd8000);
      write_register(CSR_PAR_LIMIT, 32'd12000);
      random_phase(200);

      write_register(CSR_MIN_LEN_SQ, 32'(MIN_LEN_SQ_RESET));
      write_register(CSR_PAR_LIMIT, 32'(PAR_LIMIT_RESET));
      random_phase(250);

      $display("Sent %0d plane triples across five threshold settings.", sent_count);
      $display("Solved points: %0d, of which saturated: %0d.", ok_count + saturated_count,
               saturated_count);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* three_plane_intersection.f */
+incdir+hdl
hdl/tpi_pkg.sv
hdl/three_plane_intersection.sv
tb/three_plane_intersection_checker.sv
tb/tb_three_plane_intersection.sv
